### hdl/dsab_pkg.sv
// ----------------------------------------------------------------------------
// dsab_pkg
// Shared types, sizes and codes for the host allow/block suffix matcher.
// ----------------------------------------------------------------------------
`default_nettype none

package dsab_pkg;

    // table sizes
    localparam int ENTRIES  = 64;
    localparam int MAX_LEN  = 256;

    localparam int ENTRY_AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W    = $clog2(ENTRIES + 1);
    localparam int POS_AW   = $clog2(MAX_LEN);
    localparam int LEN_W    = $clog2(MAX_LEN + 2);
    localparam int EADDR_W  = ENTRY_AW + POS_AW;
    localparam int EDEPTH   = ENTRIES * (2 ** POS_AW);

    // character constants
    localparam logic [7:0] CH_UP_A = 8'h41;
    localparam logic [7:0] CH_UP_Z = 8'h5A;
    localparam logic [7:0] CH_LO_A = 8'h61;
    localparam logic [7:0] CH_DOT  = 8'h2E;

    // opcodes
    typedef enum logic [1:0] {
        OP_CLEAR = 2'd0,
        OP_BLOCK = 2'd1,
        OP_ALLOW = 2'd2,
        OP_QUERY = 2'd3
    } t_op;

    // result codes
    typedef enum logic [2:0] {
        STS_PASS      = 3'd0,
        STS_BLOCK     = 3'd1,
        STS_STORED    = 3'd2,
        STS_DROPPED   = 3'd3,
        STS_CLEARED   = 3'd4,
        STS_HOST_LONG = 3'd5
    } t_status;

    // controller states
    typedef enum logic [2:0] {
        S_IDLE,
        S_LEN_RD,
        S_LEN_CHK,
        S_BYTE_RD,
        S_BYTE_CMP,
        S_DONE
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic in_ready;
        logic len_rd;
        logic len_chk;
        logic byte_rd;
        logic byte_cmp;
        logic next_entry;
        logic finish;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic out_full;
        logic walk_req;
        logic len_fit;
        logic cmp_more;
        logic last_entry;
    } t_dp_sts;

    // ascii upper case to lower case
    function automatic logic [7:0] fold_byte(input logic [7:0] c);
        if (c >= CH_UP_A && c <= CH_UP_Z) begin
            return c - CH_UP_A + CH_LO_A;
        end
        return c;
    endfunction

endpackage

`default_nettype wire

### hdl/dsab_if.sv
// ----------------------------------------------------------------------------
// dsab_in_if / dsab_out_if
// Valid/ready channels for input bytes and result words.
// ----------------------------------------------------------------------------
`default_nettype none

interface dsab_in_if import dsab_pkg::*; ();
    logic       valid;
    logic       ready;
    logic [1:0] opcode;
    logic [7:0] char_byte;
    logic       last_byte;

    modport source (output valid, opcode, char_byte, last_byte, input ready);
    modport sink   (input valid, opcode, char_byte, last_byte, output ready);
endinterface

interface dsab_out_if import dsab_pkg::*; ();
    logic       valid;
    logic       ready;
    logic [2:0] status;

    modport source (output valid, status, input ready);
    modport sink   (input valid, status, output ready);
endinterface

`default_nettype wire

### hdl/dsab_datapath.sv
// ----------------------------------------------------------------------------
// dsab_datapath
// Entry and host stores, build counters, compare walk registers, result word.
// ----------------------------------------------------------------------------
`default_nettype none

module dsab_datapath import dsab_pkg::*; (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  t_dp_cmd          i_cmd,
    input  wire              i_valid,
    input  wire  [1:0]       i_opcode,
    input  wire  [7:0]       i_char_byte,
    input  wire              i_last_byte,
    input  wire              i_out_ready,
    output t_dp_sts          o_sts,
    output logic             o_out_valid,
    output logic [2:0]       o_status
);

    // stores
    logic [7:0]       entry_mem [EDEPTH];
    logic [LEN_W-1:0] len_mem   [ENTRIES];
    logic             allow_mem [ENTRIES];
    logic [7:0]       host_mem  [2 ** POS_AW];

    // control state
    logic [CNT_W-1:0]    r_count,  n_count;
    logic [LEN_W-1:0]    r_pos,    n_pos;
    logic                r_ovf,    n_ovf;
    logic [LEN_W-1:0]    r_hl,     n_hl;
    logic                r_out_valid, n_out_valid;
    logic [2:0]          r_status, n_status;

    // walk registers
    logic [LEN_W-1:0]    r_hlen;
    logic [ENTRY_AW-1:0] r_ent;
    logic [LEN_W-1:0]    r_elen;
    logic                r_allow;
    logic [LEN_W-1:0]    r_off;
    logic [LEN_W-1:0]    r_idx;
    logic                r_dot;
    logic [7:0]          r_host_q;
    logic [7:0]          r_ent_q;
    logic                r_allow_hit;
    logic                r_block_hit;

    logic             accept;
    logic [1:0]       op;
    logic [7:0]       ch;
    logic             ent_full;
    logic             ent_ovf_now;
    logic [LEN_W-1:0] hl_new;
    logic             direct_load;
    logic [2:0]       direct_status;
    logic             walk_req;
    logic [LEN_W-1:0] host_rd;
    logic             cmp_eq;
    logic             cmp_hit;
    logic             cmp_more;

    assign accept = i_valid && i_cmd.in_ready;
    assign op     = i_opcode;
    assign ch     = fold_byte(i_char_byte);

    assign ent_full    = (r_count >= CNT_W'(ENTRIES)) || (r_pos >= LEN_W'(MAX_LEN));
    assign ent_ovf_now = r_ovf || ent_full;
    assign hl_new      = (r_hl < LEN_W'(MAX_LEN)) ? r_hl + LEN_W'(1) : LEN_W'(MAX_LEN + 1);

    // handling of an accepted word
    always_comb begin
        n_count       = r_count;
        n_pos         = r_pos;
        n_ovf         = r_ovf;
        n_hl          = r_hl;
        direct_load   = 1'b0;
        direct_status = STS_PASS;
        walk_req      = 1'b0;
        if (accept) begin
            case (t_op'(op))
                OP_CLEAR: begin
                    n_count       = '0;
                    n_pos         = '0;
                    n_ovf         = 1'b0;
                    direct_load   = 1'b1;
                    direct_status = STS_CLEARED;
                end
                OP_BLOCK, OP_ALLOW: begin
                    if (ent_full) begin
                        n_ovf = 1'b1;
                    end else begin
                        n_pos = r_pos + LEN_W'(1);
                    end
                    if (i_last_byte) begin
                        direct_load = 1'b1;
                        if (ent_ovf_now) begin
                            direct_status = STS_DROPPED;
                        end else begin
                            n_count       = r_count + CNT_W'(1);
                            direct_status = STS_STORED;
                        end
                        n_pos = '0;
                        n_ovf = 1'b0;
                    end
                end
                OP_QUERY: begin
                    n_hl = hl_new;
                    if (i_last_byte) begin
                        n_hl = '0;
                        if (hl_new > LEN_W'(MAX_LEN)) begin
                            direct_load   = 1'b1;
                            direct_status = STS_HOST_LONG;
                        end else if (r_count == '0) begin
                            direct_load   = 1'b1;
                            direct_status = STS_PASS;
                        end else begin
                            walk_req = 1'b1;
                        end
                    end
                end
                default: begin
                    n_hl = r_hl;
                end
            endcase
        end
    end

    // result word register
    always_comb begin
        n_out_valid = r_out_valid;
        n_status    = r_status;
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        if (direct_load) begin
            n_out_valid = 1'b1;
            n_status    = direct_status;
        end else if (i_cmd.finish) begin
            n_out_valid = 1'b1;
            n_status    = (!r_allow_hit && r_block_hit) ? STS_BLOCK : STS_PASS;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_pos       <= '0;
            r_ovf       <= 1'b0;
            r_hl        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count     <= n_count;
            r_pos       <= n_pos;
            r_ovf       <= n_ovf;
            r_hl        <= n_hl;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_status <= n_status;
    end

    // store writes
    always_ff @(posedge i_clk) begin
        if (accept && (op == OP_BLOCK || op == OP_ALLOW) && !ent_full) begin
            entry_mem[{r_count[ENTRY_AW-1:0], r_pos[POS_AW-1:0]}] <= ch;
        end
        if (accept && (op == OP_BLOCK || op == OP_ALLOW) && i_last_byte && !ent_ovf_now) begin
            len_mem[r_count[ENTRY_AW-1:0]]   <= r_pos + LEN_W'(1);
            allow_mem[r_count[ENTRY_AW-1:0]] <= (op == OP_ALLOW);
        end
        if (accept && op == OP_QUERY && r_hl < LEN_W'(MAX_LEN)) begin
            host_mem[r_hl[POS_AW-1:0]] <= ch;
        end
    end

    // compare walk
    assign host_rd = r_dot ? r_off - LEN_W'(1) : r_off + r_idx;
    assign cmp_eq  = r_dot ? (r_host_q == CH_DOT) : (r_host_q == r_ent_q);
    assign cmp_hit = cmp_eq && (r_dot || ((r_idx + LEN_W'(1) == r_elen) && r_off == '0));
    assign cmp_more = cmp_eq && !cmp_hit;

    always_ff @(posedge i_clk) begin
        if (walk_req) begin
            r_hlen      <= hl_new;
            r_ent       <= '0;
            r_allow_hit <= 1'b0;
            r_block_hit <= 1'b0;
        end
        if (i_cmd.len_rd) begin
            r_elen  <= len_mem[r_ent];
            r_allow <= allow_mem[r_ent];
        end
        if (i_cmd.len_chk) begin
            r_off <= r_hlen - r_elen;
            r_idx <= '0;
            r_dot <= 1'b0;
        end
        if (i_cmd.byte_rd) begin
            r_host_q <= host_mem[host_rd[POS_AW-1:0]];
            r_ent_q  <= entry_mem[{r_ent, r_idx[POS_AW-1:0]}];
        end
        if (i_cmd.byte_cmp) begin
            if (cmp_hit) begin
                if (r_allow) begin
                    r_allow_hit <= 1'b1;
                end else begin
                    r_block_hit <= 1'b1;
                end
            end
            if (cmp_more) begin
                if (r_idx + LEN_W'(1) == r_elen) begin
                    r_dot <= 1'b1;
                end else begin
                    r_idx <= r_idx + LEN_W'(1);
                end
            end
        end
        if (i_cmd.next_entry) begin
            r_ent <= r_ent + ENTRY_AW'(1);
        end
    end

    // status toward the controller
    assign o_sts.out_full   = r_out_valid && !i_out_ready;
    assign o_sts.walk_req   = walk_req;
    assign o_sts.len_fit    = (r_elen <= r_hlen);
    assign o_sts.cmp_more   = cmp_more;
    assign o_sts.last_entry = (CNT_W'(r_ent) + CNT_W'(1) >= r_count);

    assign o_out_valid = r_out_valid;
    assign o_status    = r_status;

endmodule

`default_nettype wire

### hdl/dsab_ctrl.sv
// ----------------------------------------------------------------------------
// dsab_ctrl
// Sequencer for intake and the entry-by-entry compare walk.
// ----------------------------------------------------------------------------
`default_nettype none

module dsab_ctrl import dsab_pkg::*; (
    input  wire     i_clk,
    input  wire     i_rst_n,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    t_state r_state, n_state;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_sts.walk_req) begin
                    n_state = S_LEN_RD;
                end
            end
            S_LEN_RD: begin
                n_state = S_LEN_CHK;
            end
            S_LEN_CHK: begin
                if (i_sts.len_fit) begin
                    n_state = S_BYTE_RD;
                end else if (i_sts.last_entry) begin
                    n_state = S_DONE;
                end else begin
                    n_state = S_LEN_RD;
                end
            end
            S_BYTE_RD: begin
                n_state = S_BYTE_CMP;
            end
            S_BYTE_CMP: begin
                if (i_sts.cmp_more) begin
                    n_state = S_BYTE_RD;
                end else if (i_sts.last_entry) begin
                    n_state = S_DONE;
                end else begin
                    n_state = S_LEN_RD;
                end
            end
            S_DONE: begin
                if (!i_sts.out_full) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // commands
    always_comb begin
        o_cmd            = '0;
        o_cmd.in_ready   = (r_state == S_IDLE) && !i_sts.out_full;
        o_cmd.len_rd     = (r_state == S_LEN_RD);
        o_cmd.len_chk    = (r_state == S_LEN_CHK);
        o_cmd.byte_rd    = (r_state == S_BYTE_RD);
        o_cmd.byte_cmp   = (r_state == S_BYTE_CMP);
        o_cmd.next_entry = ((r_state == S_LEN_CHK) && !i_sts.len_fit) ||
                           ((r_state == S_BYTE_CMP) && !i_sts.cmp_more);
        o_cmd.finish     = (r_state == S_DONE) && !i_sts.out_full;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

### hdl/domain_suffix_allow_block_match.sv
// ----------------------------------------------------------------------------
// domain_suffix_allow_block_match
// Host allow/block table with label-boundary suffix matching.
// ----------------------------------------------------------------------------
// Input channel i_in carries one byte word: opcode (clear, block entry byte,
// allow entry byte, host byte), char_byte and last_byte. Output channel o_out
// carries a status word on every clear and every last byte.
// Entry and host bytes are taken one per cycle while the sequencer is idle
// and no result is stalled; a clear, an entry's last byte, an over-long host
// or a host on an empty table gives its status the cycle after acceptance.
// Otherwise a host's last byte starts a walk over the stored entries: per
// entry a length read and check, then a store read and a compare per byte,
// plus a read and compare for the '.' check; the walk stops on an entry at
// its first mismatching byte. Entry and host stores have one read port each.
// Reset empties the table and host buffer; no clearing pass is needed.
// The status word sits in an output register; while the receiver stalls,
// the block holds it and takes no new word until it is taken or taken
// in the same cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module domain_suffix_allow_block_match import dsab_pkg::*; (
    input  wire         i_clk,
    input  wire         i_rst_n,
    dsab_in_if.sink     i_in,
    dsab_out_if.source  o_out
);

    t_dp_cmd cmd;
    t_dp_sts sts;

    // sequencer
    dsab_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    // stores and walk datapath
    dsab_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_valid     (i_in.valid),
        .i_opcode    (i_in.opcode),
        .i_char_byte (i_in.char_byte),
        .i_last_byte (i_in.last_byte),
        .i_out_ready (o_out.ready),
        .o_sts       (sts),
        .o_out_valid (o_out.valid),
        .o_status    (o_out.status)
    );

    assign i_in.ready = cmd.in_ready;

endmodule

`default_nettype wire

### hdl/dsab_checker.sv
// ----------------------------------------------------------------------------
// dsab_checker
// Port-level checks for the host allow/block matcher, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

module dsab_checker import dsab_pkg::*; (
    input wire       i_clk,
    input wire       i_rst_n,
    input wire       i_in_valid,
    input wire       i_in_ready,
    input wire [1:0] i_in_opcode,
    input wire       i_in_last,
    input wire       i_out_valid,
    input wire       i_out_ready,
    input wire [2:0] i_out_status
);

    // stalled word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_status))
        else $error("result word dropped or changed while stalled");

    // only defined status codes
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_out_status <= STS_HOST_LONG))
        else $error("undefined status code");

    // no intake while a result is stalled
    a_no_take_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_ready |-> !(i_out_valid && !i_out_ready))
        else $error("word taken while result stalled");

    // a middle byte gives no result
    a_mid_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready && !i_in_last && i_in_opcode != OP_CLEAR
        |=> !$rose(i_out_valid))
        else $error("result after a middle byte");

endmodule

bind domain_suffix_allow_block_match dsab_checker u_dsab_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in.valid),
    .i_in_ready   (i_in.ready),
    .i_in_opcode  (i_in.opcode),
    .i_in_last    (i_in.last_byte),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_out_status (o_out.status)
);

`default_nettype wire
